// ===== src/dfdf_pkg.sv =====
// ----------------------------------------------------------------------------
// dfdf_pkg
// Shared types, constants and the CORDIC step table of the decoupling filter.
// ----------------------------------------------------------------------------
package dfdf_pkg;

  localparam int SampleWidth  = 16;
  localparam int AngleWidth   = 16;
  localparam int GainWidth    = 17;
  localparam int CordicSteps  = 16;
  localparam int StepBits     = 4;
  localparam int AccWidth     = 40;
  localparam int CordicWidth  = 36;
  localparam logic signed [CordicWidth-1:0] CordicX0 = 36'sd652032874;

  // configuration register indexes
  localparam logic [0:0] RegFeedbackGain = 1'b0;
  localparam logic [0:0] RegInputGain    = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CORDIC,
    ST_DECOUPLE,
    ST_FILTER,
    ST_DONE
  } dfdf_state_t;

  // command from controller to datapath
  typedef struct packed {
    logic load;        // capture input word, start cordic
    logic cordic_step; // one rotation
    logic mac_clear;   // clear accumulator
    logic mac_step;    // one multiply-accumulate term
    logic dec_commit;  // store raw value of current lane
    logic flt_commit;  // store filtered value of current lane
    logic [1:0] lane;
    logic [1:0] term;
    logic [StepBits-1:0] iter;
  } dfdf_cmd_t;

  function automatic logic signed [CordicWidth-1:0] atan_step(input logic [StepBits-1:0] i);
    case (i)
      4'd0:    atan_step = 36'sd536870912;
      4'd1:    atan_step = 36'sd316933406;
      4'd2:    atan_step = 36'sd167458907;
      4'd3:    atan_step = 36'sd85004756;
      4'd4:    atan_step = 36'sd42667331;
      4'd5:    atan_step = 36'sd21354465;
      4'd6:    atan_step = 36'sd10679838;
      4'd7:    atan_step = 36'sd5340245;
      4'd8:    atan_step = 36'sd2670163;
      4'd9:    atan_step = 36'sd1335087;
      4'd10:   atan_step = 36'sd667544;
      4'd11:   atan_step = 36'sd333772;
      4'd12:   atan_step = 36'sd166886;
      4'd13:   atan_step = 36'sd83443;
      4'd14:   atan_step = 36'sd41722;
      default: atan_step = 36'sd20861;
    endcase
  endfunction

  // round half up by 2^15 and saturate to a sample
  function automatic logic signed [SampleWidth-1:0] round_sat(
      input logic signed [AccWidth-1:0] acc);
    logic signed [AccWidth-1:0] r;
    r = (acc + AccWidth'(16384)) >>> 15;
    if (r > AccWidth'(32767))
      round_sat = 16'sh7fff;
    else if (r < -AccWidth'(32768))
      round_sat = 16'sh8000;
    else
      round_sat = r[SampleWidth-1:0];
  endfunction

endpackage

// ===== src/dual_frame_decoupling_filter_unit.sv =====
// ----------------------------------------------------------------------------
// dual_frame_decoupling_filter_unit
// Decoupling cell with first-order filters for a dual synchronous frame PLL.
// ----------------------------------------------------------------------------
// an input word runs through the 16 cordic steps, the decoupling terms of the
// 4 lanes, the filter terms of the 4 lanes and the output register
// a new input word is taken only when idle, set by the sequential cordic and
// the single shared multiplier; a held result word stalls the next input word
// reset: synchronous active low; gains and filter state clear to zero
module dual_frame_decoupling_filter_unit import dfdf_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // grid_angle, pos_d_in, pos_q_in, neg_d_in, neg_q_in
  input  logic [79:0]  in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // pos_d_out, pos_q_out, neg_d_out, neg_q_out,
  // pos_d_filtered, pos_q_filtered, neg_d_filtered, neg_q_filtered
  output logic [127:0] out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_index,
  input  logic [16:0]  cfg_data
);

  dfdf_cmd_t cmd;
  logic in_ready, res_valid, in_fire;
  logic out_valid_r;
  logic [127:0] out_data_r, result;

  assign in_tready = in_ready;
  assign in_fire   = in_tvalid && in_ready;
  assign cfg_ready = 1'b1;

  dfdf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .out_busy (out_valid_r && !out_tready),
    .in_ready (in_ready),
    .res_valid(res_valid),
    .cmd      (cmd)
  );

  dfdf_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cfg_fire  (cfg_valid && cfg_ready),
    .cfg_sel   (cfg_index[0]),
    .cfg_hit   (cfg_index[7:1] == 7'd0),
    .cfg_value (cfg_data),
    .grid_angle(in_tdata[15:0]),
    .samples   (in_tdata[79:16]),
    .result    (result)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (res_valid) out_data_r <= result;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== src/dfdf_ctrl.sv =====
// ----------------------------------------------------------------------------
// dfdf_ctrl
// Sequencer: cordic rotations, then decoupling and filter terms lane by lane.
// ----------------------------------------------------------------------------
module dfdf_ctrl import dfdf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_fire,
  input  logic      out_busy,
  output logic      in_ready,
  output logic      res_valid,
  output dfdf_cmd_t cmd
);

  dfdf_state_t state_r, state_nxt;
  logic [StepBits-1:0] iter_r, iter_nxt;
  logic [1:0] lane_r, lane_nxt;
  logic [1:0] term_r, term_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      iter_r  <= '0;
      lane_r  <= '0;
      term_r  <= '0;
    end else begin
      state_r <= state_nxt;
      iter_r  <= iter_nxt;
      lane_r  <= lane_nxt;
      term_r  <= term_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    iter_nxt  = iter_r;
    lane_nxt  = lane_r;
    term_nxt  = term_r;
    cmd       = '0;
    cmd.lane  = lane_r;
    cmd.term  = term_r;
    cmd.iter  = iter_r;
    in_ready  = 1'b0;
    res_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          cmd.load  = 1'b1;
          iter_nxt  = '0;
          state_nxt = ST_CORDIC;
        end
      end
      ST_CORDIC: begin
        cmd.cordic_step = 1'b1;
        iter_nxt = iter_r + 1'b1;
        if (iter_r == StepBits'(CordicSteps - 1)) begin
          lane_nxt  = '0;
          term_nxt  = '0;
          cmd.mac_clear = 1'b1;
          state_nxt = ST_DECOUPLE;
        end
      end
      ST_DECOUPLE: begin
        // terms: input, first product, second product, then commit
        if (term_r == 2'd3) begin
          cmd.dec_commit = 1'b1;
          cmd.mac_clear  = 1'b1;
          term_nxt = '0;
          lane_nxt = lane_r + 1'b1;
          if (lane_r == 2'd3) state_nxt = ST_FILTER;
        end else begin
          cmd.mac_step = 1'b1;
          term_nxt = term_r + 1'b1;
        end
      end
      ST_FILTER: begin
        // terms: feedback product, input-gain product, then commit
        if (term_r == 2'd2) begin
          cmd.flt_commit = 1'b1;
          cmd.mac_clear  = 1'b1;
          term_nxt = '0;
          lane_nxt = lane_r + 1'b1;
          if (lane_r == 2'd3) state_nxt = ST_DONE;
        end else begin
          cmd.mac_step = 1'b1;
          term_nxt = term_r + 1'b1;
        end
      end
      ST_DONE: begin
        if (!out_busy) begin
          res_valid = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ===== src/dfdf_datapath.sv =====
// ----------------------------------------------------------------------------
// dfdf_datapath
// Shared cordic rotator, one multiply-accumulate unit and the filter state.
// ----------------------------------------------------------------------------
module dfdf_datapath import dfdf_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dfdf_cmd_t                     cmd,
  input  logic                          cfg_fire,
  input  logic [0:0]                    cfg_sel,
  input  logic                          cfg_hit,
  input  logic signed [GainWidth-1:0]   cfg_value,
  input  logic [AngleWidth-1:0]         grid_angle,
  input  logic [4*SampleWidth-1:0]      samples,
  output logic [8*SampleWidth-1:0]      result
);

  logic signed [GainWidth-1:0] fb_gain_r, in_gain_r;
  logic signed [SampleWidth-1:0] filt_r [4];
  logic signed [SampleWidth-1:0] prev_r [4];
  logic signed [SampleWidth-1:0] raw_r [4];
  logic signed [SampleWidth-1:0] newf_r [4];
  logic signed [SampleWidth-1:0] x_in_r [4];
  logic signed [CordicWidth-1:0] cx_r, cy_r, cz_r;
  logic flip_r;
  logic signed [AccWidth-1:0] acc_r;
  logic signed [SampleWidth-1:0] sin_v, cos_v;
  logic signed [CordicWidth-1:0] fx, fy;
  logic [31:0] turn, turn_adj;
  logic signed [SampleWidth+1:0] op_a;
  logic signed [SampleWidth+1:0] op_b;
  logic signed [AccWidth-1:0] prod;
  logic signed [AccWidth-1:0] term_v;
  logic signed [SampleWidth-1:0] fv_a, fv_b;
  // filter phase marker: set by the last decoupling commit
  logic raw_sel_filter, filt_phase_r;

  // configuration registers and filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fb_gain_r <= '0;
      in_gain_r <= '0;
      for (int i = 0; i < 4; i++) begin
        filt_r[i] <= '0;
        prev_r[i] <= '0;
      end
    end else begin
      if (cfg_fire && cfg_hit) begin
        if (cfg_sel == RegFeedbackGain) fb_gain_r <= cfg_value;
        else                            in_gain_r <= cfg_value;
      end
      if (cmd.flt_commit && cmd.lane == 2'd3) begin
        for (int i = 0; i < 3; i++) begin
          filt_r[i] <= newf_r[i];
          prev_r[i] <= raw_r[i];
        end
        filt_r[3] <= round_sat(acc_r);
        prev_r[3] <= raw_r[3];
      end
    end
  end

  // doubled angle on a 32-bit turn, wraps at one full turn; left half folded
  assign turn     = {grid_angle[AngleWidth-2:0], {(33 - AngleWidth){1'b0}}};
  assign turn_adj = (turn[31:30] == 2'b01 || turn[31:30] == 2'b10) ?
                    turn - 32'h8000_0000 : turn;

  // cordic rotator, one step a cycle
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      flip_r <= (turn[31:30] == 2'b01 || turn[31:30] == 2'b10);
      cx_r   <= CordicX0;
      cy_r   <= '0;
      cz_r   <= CordicWidth'(signed'(turn_adj));
      for (int i = 0; i < 4; i++)
        x_in_r[i] <= samples[i*SampleWidth +: SampleWidth];
    end else if (cmd.cordic_step) begin
      if (!cz_r[CordicWidth-1]) begin
        cx_r <= cx_r - (cy_r >>> cmd.iter);
        cy_r <= cy_r + (cx_r >>> cmd.iter);
        cz_r <= cz_r - atan_step(cmd.iter);
      end else begin
        cx_r <= cx_r + (cy_r >>> cmd.iter);
        cy_r <= cy_r - (cx_r >>> cmd.iter);
        cz_r <= cz_r + atan_step(cmd.iter);
      end
    end
  end

  assign fx = flip_r ? -cx_r : cx_r;
  assign fy = flip_r ? -cy_r : cy_r;

  always_comb begin
    logic signed [CordicWidth-1:0] rc, rs;
    rc = (fx + CordicWidth'(16384)) >>> 15;
    rs = (fy + CordicWidth'(16384)) >>> 15;
    if (rc > CordicWidth'(32767)) cos_v = 16'sh7fff;
    else if (rc < -CordicWidth'(32768)) cos_v = 16'sh8000;
    else cos_v = rc[SampleWidth-1:0];
    if (rs > CordicWidth'(32767)) sin_v = 16'sh7fff;
    else if (rs < -CordicWidth'(32768)) sin_v = 16'sh8000;
    else sin_v = rs[SampleWidth-1:0];
  end

  // operand selection for the shared multiplier
  always_comb begin
    op_a = '0;
    op_b = '0;
    term_v = '0;
    // other-sequence filtered values for the lane
    fv_a = cmd.lane[1] ? filt_r[0] : filt_r[2];
    fv_b = cmd.lane[1] ? filt_r[1] : filt_r[3];
    if (cmd.dec_commit || !cmd.flt_commit) begin
      case (cmd.term)
        2'd0: begin
          op_a = 18'(x_in_r[cmd.lane]);
          op_b = 18'sd32768;
        end
        2'd1: begin
          op_a = 18'(fv_a);
          // pos_d:-c  pos_q:+s  neg_d:-c  neg_q:-s
          case (cmd.lane)
            2'd1:    op_b = 18'(sin_v);
            2'd3:    op_b = -18'(sin_v);
            default: op_b = -18'(cos_v);
          endcase
        end
        default: begin
          op_a = 18'(fv_b);
          // pos_d:-s  pos_q:-c  neg_d:+s  neg_q:-c
          case (cmd.lane)
            2'd0:    op_b = -18'(sin_v);
            2'd2:    op_b = 18'(sin_v);
            default: op_b = -18'(cos_v);
          endcase
        end
      endcase
    end
    if (raw_sel_filter) begin
      if (cmd.term == 2'd0) begin
        op_a = 18'(filt_r[cmd.lane]);
        op_b = 18'(fb_gain_r);
      end else begin
        op_a = 18'(prev_r[cmd.lane]) + 18'(raw_r[cmd.lane]);
        op_b = 18'(in_gain_r);
      end
    end
    prod = AccWidth'(op_a) * AccWidth'(op_b);
    term_v = prod;
  end

  assign raw_sel_filter = filt_phase_r;

  // accumulator and lane results
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filt_phase_r <= 1'b0;
    end else begin
      if (cmd.load) filt_phase_r <= 1'b0;
      else if (cmd.dec_commit && cmd.lane == 2'd3) filt_phase_r <= 1'b1;
    end
    if (cmd.mac_clear) acc_r <= '0;
    else if (cmd.mac_step) acc_r <= acc_r + term_v;
    if (cmd.dec_commit) raw_r[cmd.lane] <= round_sat(acc_r);
    if (cmd.flt_commit) newf_r[cmd.lane] <= round_sat(acc_r);
  end

  // result word
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      result[i*SampleWidth +: SampleWidth]     = prev_r[i];
      result[(i+4)*SampleWidth +: SampleWidth] = filt_r[i];
    end
  end

endmodule
